[rtl/tsa_pkg.sv]
`default_nettype none

package tsa_pkg;

	// Table geometry
	localparam int POOL_CAPACITY = 256;
	localparam int IDX_W         = $clog2(POOL_CAPACITY);
	localparam int SLOT_W        = 16;
	localparam int OWNER_W       = 16;
	localparam int STATUS_W      = 3;
	localparam int OPCODE_W      = 2;

	// Free-slot search: the used bits are summarized per group of GRP_W slots
	localparam int GRP_W     = 16;
	localparam int LOW_W     = $clog2(GRP_W);
	localparam int NUM_GRP   = (POOL_CAPACITY + GRP_W - 1) / GRP_W;
	localparam int GRP_IDX_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_SET   = 2'd1,
		OP_GET   = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_SAME  = 3'd1,
		ST_TAKEN = 3'd2,
		ST_EMPTY = 3'd3,
		ST_RANGE = 3'd4,
		ST_FULL  = 3'd5
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;   // input beat accepted: latch request, read table
		logic commit;    // decide, update table, load result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic wr_en;     // current request claims a slot
	} sts_t;

endpackage

`default_nettype wire

[rtl/tsa_ctrl.sv]
`default_nettype none

module tsa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tsa_pkg::cmd_t      cmd,
	input  wire tsa_pkg::sts_t sts
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Handshake and commands
	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	// State and result-valid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_EXEC;
					end
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_capture_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_EXEC))
		else $error("accepted beat did not move to execute");

	a_write_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.wr_en && (state_q == S_IDLE)) |-> !cmd.commit)
		else $error("commit outside execute state");

	a_commit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not present a result beat");
`endif

endmodule

`default_nettype wire

[rtl/tsa_datapath.sv]
`default_nettype none

module tsa_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tsa_pkg::cmd_t                 cmd,
	output tsa_pkg::sts_t                      sts,
	input  wire logic [tsa_pkg::OPCODE_W-1:0]  opcode,
	input  wire logic [tsa_pkg::SLOT_W-1:0]    slot_index,
	input  wire logic [tsa_pkg::OWNER_W-1:0]   owner_id,
	output logic      [tsa_pkg::STATUS_W-1:0]  status,
	output logic      [tsa_pkg::SLOT_W-1:0]    granted_slot,
	output logic      [tsa_pkg::OWNER_W-1:0]   owner_found
);

	localparam int SCAN_W = tsa_pkg::NUM_GRP * tsa_pkg::GRP_W;

	// Table state
	logic [tsa_pkg::POOL_CAPACITY-1:0] used_q;
	logic [tsa_pkg::OWNER_W-1:0]       owner_mem [tsa_pkg::POOL_CAPACITY];

	// Request and lookup registers
	logic [tsa_pkg::OPCODE_W-1:0] op_q;
	logic [tsa_pkg::SLOT_W-1:0]   idx_q;
	logic [tsa_pkg::OWNER_W-1:0]  own_q;
	logic                         used_at_q;
	logic [tsa_pkg::OWNER_W-1:0]  rd_q;
	logic [tsa_pkg::NUM_GRP-1:0]  grp_any_q;
	logic [tsa_pkg::NUM_GRP-1:0][tsa_pkg::LOW_W-1:0] grp_low_q;

	// Result registers
	logic [tsa_pkg::STATUS_W-1:0] status_q;
	logic [tsa_pkg::SLOT_W-1:0]   granted_q;
	logic [tsa_pkg::OWNER_W-1:0]  found_q;

	logic [SCAN_W-1:0]                               free_vec;
	logic [tsa_pkg::NUM_GRP-1:0]                     grp_any_d;
	logic [tsa_pkg::NUM_GRP-1:0][tsa_pkg::LOW_W-1:0] grp_low_d;

	logic [tsa_pkg::GRP_IDX_W-1:0] sel_grp;
	logic                          any_free;
	logic [tsa_pkg::IDX_W-1:0]     alloc_slot;
	logic                          in_rng;
	logic [tsa_pkg::STATUS_W-1:0]  status_d;
	logic [tsa_pkg::SLOT_W-1:0]    granted_d;
	logic [tsa_pkg::OWNER_W-1:0]   found_d;
	logic                          wr_en;
	logic [tsa_pkg::IDX_W-1:0]     wr_addr;

	// Free map: slot 0 and slots past capacity never count as free
	always_comb begin
		for (int s = 0; s < SCAN_W; s++) begin
			if ((s > 0) && (s < tsa_pkg::POOL_CAPACITY)) begin
				free_vec[s] = !used_q[s];
			end else begin
				free_vec[s] = 1'b0;
			end
		end
	end

	// First level of the search: lowest free slot inside each group
	always_comb begin
		for (int g = 0; g < tsa_pkg::NUM_GRP; g++) begin
			grp_any_d[g] = |free_vec[g*tsa_pkg::GRP_W +: tsa_pkg::GRP_W];
			grp_low_d[g] = '0;
			for (int b = tsa_pkg::GRP_W - 1; b >= 0; b--) begin
				if (free_vec[g*tsa_pkg::GRP_W + b]) begin
					grp_low_d[g] = tsa_pkg::LOW_W'(b);
				end
			end
		end
	end

	// Capture the request, the table entry and the group summary
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= opcode;
			idx_q     <= slot_index;
			own_q     <= owner_id;
			used_at_q <= used_q[slot_index[tsa_pkg::IDX_W-1:0]];
			rd_q      <= owner_mem[slot_index[tsa_pkg::IDX_W-1:0]];
			grp_any_q <= grp_any_d;
			grp_low_q <= grp_low_d;
		end
		if (cmd.commit && wr_en) begin
			owner_mem[wr_addr] <= own_q;
		end
	end

	// Second level of the search: lowest group holding a free slot
	always_comb begin
		sel_grp = '0;
		for (int g = tsa_pkg::NUM_GRP - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				sel_grp = tsa_pkg::GRP_IDX_W'(g);
			end
		end
		any_free   = |grp_any_q;
		alloc_slot = tsa_pkg::IDX_W'({sel_grp, grp_low_q[sel_grp]});
	end

	assign in_rng = (idx_q < tsa_pkg::SLOT_W'(tsa_pkg::POOL_CAPACITY));

	// Decide the result and the table update
	always_comb begin
		status_d  = tsa_pkg::ST_RANGE;
		granted_d = '0;
		found_d   = '0;
		wr_en     = 1'b0;
		wr_addr   = idx_q[tsa_pkg::IDX_W-1:0];
		unique case (op_q)
			tsa_pkg::OP_ALLOC: begin
				wr_addr = alloc_slot;
				if (any_free) begin
					status_d  = tsa_pkg::ST_OK;
					granted_d = tsa_pkg::SLOT_W'(alloc_slot);
					wr_en     = 1'b1;
				end else begin
					status_d = tsa_pkg::ST_FULL;
				end
			end
			tsa_pkg::OP_SET: begin
				if (!in_rng) begin
					status_d = tsa_pkg::ST_RANGE;
				end else if (used_at_q) begin
					if (rd_q == own_q) begin
						status_d  = tsa_pkg::ST_SAME;
						granted_d = idx_q;
					end else begin
						status_d = tsa_pkg::ST_TAKEN;
					end
				end else begin
					status_d  = tsa_pkg::ST_OK;
					granted_d = idx_q;
					wr_en     = 1'b1;
				end
			end
			tsa_pkg::OP_GET: begin
				if (!in_rng) begin
					status_d = tsa_pkg::ST_RANGE;
				end else if (!used_at_q) begin
					status_d = tsa_pkg::ST_EMPTY;
				end else begin
					status_d = tsa_pkg::ST_OK;
					found_d  = rd_q;
				end
			end
			default: begin
				status_d = tsa_pkg::ST_RANGE;
			end
		endcase
	end

	assign sts.wr_en = wr_en;

	// Used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.commit && wr_en) begin
			used_q[wr_addr] <= 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q  <= status_d;
			granted_q <= granted_d;
			found_q   <= found_d;
		end
	end

	assign status       = status_q;
	assign granted_slot = granted_q;
	assign owner_found  = found_q;

`ifndef ASSERT_OFF
	a_claim_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && wr_en) |-> !used_q[wr_addr])
		else $error("claim targets a slot already in use");

	a_claim_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && wr_en) |=> used_q[$past(wr_addr)])
		else $error("claimed slot not marked used");

	a_alloc_skips_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (op_q == tsa_pkg::OP_ALLOC) && any_free) |=> (granted_q != '0))
		else $error("allocate granted the reserved slot");
`endif

endmodule

`default_nettype wire

[rtl/tag_slot_allocator_top.sv]
`default_nettype none

// Tag slot allocator: a table of 256 slots, each empty or owned by a 16-bit
// owner handle, all empty after reset. Opcode 0 claims the lowest free slot
// from 1 upward, opcode 1 claims a named slot, opcode 2 reads a slot's owner;
// one result beat per input beat, in order. The accept cycle of an item
// latches the request, reads the owner memory and registers a per-group
// summary of the used bits; the execute state then finishes the lowest-free
// search, writes the table and loads the result register. A new item is
// accepted in the cycle after that load, while the result still waits; the
// decide cycle of the following item holds until the result register is taken.
module tag_slot_allocator_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [tsa_pkg::OPCODE_W-1:0]  opcode,
	input  wire logic [tsa_pkg::SLOT_W-1:0]    slot_index,
	input  wire logic [tsa_pkg::OWNER_W-1:0]   owner_id,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [tsa_pkg::STATUS_W-1:0]  status,
	output logic      [tsa_pkg::SLOT_W-1:0]    granted_slot,
	output logic      [tsa_pkg::OWNER_W-1:0]   owner_found
);

	tsa_pkg::cmd_t cmd;
	tsa_pkg::sts_t sts;

	tsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tsa_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.slot_index   (slot_index),
		.owner_id     (owner_id),
		.status       (status),
		.granted_slot (granted_slot),
		.owner_found  (owner_found)
	);

endmodule

`default_nettype wire
